### hw/rtl/tans_pkg.sv
package tans_pkg;

  // Fixed field widths
  localparam int REQ_W     = 2;
  localparam int SYM_IN_W  = 8;
  localparam int CNT_W     = 13;
  localparam int LOG_W     = 4;
  localparam int NBITS_W   = 4;
  localparam int STATUS_W  = 2;

  // Smallest table size exponent accepted
  localparam logic [LOG_W-1:0] MIN_TABLE_LOG = 4'd4;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_BUILD  = 2'd1,
    REQ_ENCODE = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  // Status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_ZERO_SYM = 2'd2,
    ST_NO_TABLE = 2'd3
  } status_t;

endpackage

### hw/rtl/tans_table_build_and_encode.sv
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+--------------------------
// input    | in_req_type, in_symbol, in_count_value             | start & !busy
// result   | out_code_bits, out_bit_count, out_coder_state,     | out_valid, one cycle
//          | out_status                                         |
// config   | cfg_table_log                                      | cfg_valid & cfg_ready
//
// Load, no-op and encodes before a build answer one cycle after acceptance;
// an encode of an absent symbol answers after two, a bad-sum build after the sum pass.
// Encode takes 3 cycles: symbol table read, then dependent transition table read.
// Build takes about ALPHABET_SIZE (sum pass) + 2*ALPHABET_SIZE + L (spread)
// + 3*L (transition fill) cycles; one memory write port per pass sets this.
// Synchronous active-low reset clears control state and the count valid bits.
// The receiver cannot stall: each result is shown for exactly one cycle.
module tans_table_build_and_encode #(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_TABLE_LOG = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [tans_pkg::REQ_W-1:0]        in_req_type,
  input  logic [tans_pkg::SYM_IN_W-1:0]     in_symbol,
  input  logic [tans_pkg::CNT_W-1:0]        in_count_value,
  output logic                              out_valid,
  output logic [MAX_TABLE_LOG-1:0]          out_code_bits,
  output logic [tans_pkg::NBITS_W-1:0]      out_bit_count,
  output logic [MAX_TABLE_LOG:0]            out_coder_state,
  output logic [tans_pkg::STATUS_W-1:0]     out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tans_pkg::LOG_W-1:0]        cfg_table_log
);

  import tans_pkg::*;

  localparam int SYM_W   = $clog2(ALPHABET_SIZE);
  localparam int TBL_W   = MAX_TABLE_LOG;
  localparam int TBL     = 1 << MAX_TABLE_LOG;
  localparam int ST_W    = MAX_TABLE_LOG + 1;
  localparam int SUM_W   = SYM_W + CNT_W;
  localparam int CMP_W   = (SUM_W > ST_W) ? SUM_W : ST_W;
  localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(ALPHABET_SIZE - 1);

  // Per-symbol encode entry
  typedef struct packed {
    logic [ST_W-1:0]    f;
    logic [ST_W-1:0]    cum;
    logic [NBITS_W-1:0] sh;
    logic [ST_W:0]      th;
  } sym_ent_t;

  localparam int ENT_W = $bits(sym_ent_t);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_SUMCHK, S_RDCNT, S_SYMW, S_SPREAD,
    S_TR_RD, S_TR_SYM, S_TR_WR, S_ENC_SYM, S_ENC_TR
  } state_t;

  state_t               state_r, state_nxt;
  logic [LOG_W-1:0]     log_r, log_nxt;
  logic                 ready_r, ready_nxt;
  logic [ST_W-1:0]      cur_r, cur_nxt;
  logic [SYM_W-1:0]     sym_i_r, sym_i_nxt;
  logic                 pend_r, pend_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [ST_W-1:0]      cum_r, cum_nxt;
  logic [ST_W-1:0]      left_r, left_nxt;
  logic [TBL_W-1:0]     idx_r, idx_nxt;
  logic [TBL_W-1:0]     tcnt_r, tcnt_nxt;
  logic [SYM_W-1:0]     s_r, s_nxt;
  logic [TBL_W-1:0]     enc_bits_r, enc_bits_nxt;
  logic [NBITS_W-1:0]   enc_nb_r, enc_nb_nxt;
  logic                 cvld_r, cvld_nxt;
  logic [ALPHABET_SIZE-1:0] cvalid_r, cvalid_nxt;

  logic                 ov_r, ov_nxt;
  logic [TBL_W-1:0]     obits_r, obits_nxt;
  logic [NBITS_W-1:0]   onb_r, onb_nxt;
  logic [ST_W-1:0]      ost_r, ost_nxt;
  status_t              ostat_r, ostat_nxt;

  // Memory ports
  logic                 cnt_we;
  logic [SYM_W-1:0]     cnt_wa;
  logic [CNT_W-1:0]     cnt_rd;
  logic                 sym_we;
  logic [SYM_W-1:0]     sym_wa, sym_ra;
  sym_ent_t             sym_wd;
  logic [ENT_W-1:0]     sym_rd;
  logic                 nidx_we;
  logic [SYM_W-1:0]     nidx_wa;
  logic [ST_W-1:0]      nidx_wd, nidx_rd;
  logic                 spr_we;
  logic [SYM_W-1:0]     spr_rd;
  logic                 tr_we;
  logic [TBL_W-1:0]     tr_wa, tr_ra;
  logic [ST_W-1:0]      tr_wd, tr_rd;

  // Derived table geometry
  logic [LOG_W-1:0]     eff_lg;
  logic [ST_W-1:0]      l_val;
  logic [TBL_W-1:0]     l_mask;
  logic [ST_W-1:0]      step;
  logic [CNT_W-1:0]     rd_cnt;
  logic [SUM_W-1:0]     total;
  logic                 sym_in_range;
  logic [SYM_W-1:0]     in_sym;

  // Build-side entry math
  logic [ST_W-1:0]      bf;
  logic [ST_W-1:0]      bf_m1;
  logic [NBITS_W-1:0]   blen;
  logic [NBITS_W-1:0]   bnb;
  logic [ST_W:0]        bth;

  // Encode-side math
  sym_ent_t             ent;
  logic [NBITS_W-1:0]   enb;
  logic [ST_W-1:0]      epos;
  logic [ST_W-1:0]      ebits;

  tans_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET_SIZE)) u_cnt_ram (
    .clk(clk), .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(in_count_value),
    .rd_addr(sym_i_r), .rd_data(cnt_rd)
  );

  tans_ram #(.WIDTH(ENT_W), .DEPTH(ALPHABET_SIZE)) u_sym_ram (
    .clk(clk), .wr_en(sym_we), .wr_addr(sym_wa), .wr_data(sym_wd),
    .rd_addr(sym_ra), .rd_data(sym_rd)
  );

  tans_ram #(.WIDTH(ST_W), .DEPTH(ALPHABET_SIZE)) u_nidx_ram (
    .clk(clk), .wr_en(nidx_we), .wr_addr(nidx_wa), .wr_data(nidx_wd),
    .rd_addr(spr_rd), .rd_data(nidx_rd)
  );

  tans_ram #(.WIDTH(SYM_W), .DEPTH(TBL)) u_spread_ram (
    .clk(clk), .wr_en(spr_we), .wr_addr(idx_r), .wr_data(sym_i_r),
    .rd_addr(tcnt_r), .rd_data(spr_rd)
  );

  tans_ram #(.WIDTH(ST_W), .DEPTH(TBL)) u_trans_ram (
    .clk(clk), .wr_en(tr_we), .wr_addr(tr_wa), .wr_data(tr_wd),
    .rd_addr(tr_ra), .rd_data(tr_rd)
  );

  // Geometry from the saturated table log
  always_comb begin
    eff_lg = log_r;
    if (log_r < MIN_TABLE_LOG) eff_lg = MIN_TABLE_LOG;
    if (log_r > LOG_W'(MAX_TABLE_LOG)) eff_lg = LOG_W'(MAX_TABLE_LOG);
    l_val  = ST_W'(1) << eff_lg;
    l_mask = TBL_W'(l_val - ST_W'(1));
    step   = ST_W'((l_val >> 3) * ST_W'(5) + ST_W'(3));
  end

  assign rd_cnt       = cvld_r ? cnt_rd : '0;
  assign total        = sum_r + SUM_W'(rd_cnt);
  assign sym_in_range = ({1'b0, in_symbol} < (SYM_IN_W + 1)'(ALPHABET_SIZE));
  assign in_sym       = SYM_W'(in_symbol);

  // Shift count: nb = lg - bitlen(f-1), f=0 gives 1
  always_comb begin
    bf    = ST_W'(rd_cnt);
    bf_m1 = bf - ST_W'(1);
    blen  = '0;
    for (int k = 0; k < ST_W; k++) begin
      if (bf_m1[k]) blen = NBITS_W'(k + 1);
    end
    if (bf == '0) begin
      bnb = NBITS_W'(1);
      bth = '0;
    end else begin
      bnb = eff_lg - blen;
      bth = {bf, 1'b0} << bnb;
    end
  end

  // Encode step from the symbol entry
  always_comb begin
    ent   = sym_ent_t'(sym_rd);
    enb   = ent.sh + NBITS_W'({1'b0, cur_r} >= ent.th);
    epos  = ent.cum + (cur_r >> enb) - ent.f;
    ebits = cur_r & ~({ST_W{1'b1}} << enb);
  end

  // Control
  always_comb begin
    state_nxt    = state_r;
    log_nxt      = log_r;
    ready_nxt    = ready_r;
    cur_nxt      = cur_r;
    sym_i_nxt    = sym_i_r;
    pend_nxt     = pend_r;
    sum_nxt      = sum_r;
    cum_nxt      = cum_r;
    left_nxt     = left_r;
    idx_nxt      = idx_r;
    tcnt_nxt     = tcnt_r;
    s_nxt        = s_r;
    enc_bits_nxt = enc_bits_r;
    enc_nb_nxt   = enc_nb_r;
    cvld_nxt     = cvalid_r[sym_i_r];
    cvalid_nxt   = cvalid_r;
    ov_nxt       = 1'b0;
    obits_nxt    = '0;
    onb_nxt      = '0;
    ost_nxt      = cur_r;
    ostat_nxt    = ST_OK;

    cnt_we  = 1'b0;
    cnt_wa  = in_sym;
    sym_we  = 1'b0;
    sym_wa  = sym_i_r;
    sym_ra  = in_sym;
    sym_wd  = '{f: bf, cum: cum_r, sh: bnb, th: bth};
    nidx_we = 1'b0;
    nidx_wa = sym_i_r;
    nidx_wd = cum_r;
    spr_we  = 1'b0;
    tr_we   = 1'b0;
    tr_wa   = nidx_rd[TBL_W-1:0];
    tr_wd   = l_val + ST_W'(tcnt_r);
    tr_ra   = epos[TBL_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (req_t'(in_req_type))
            REQ_LOAD: begin
              ov_nxt = 1'b1;
              if (sym_in_range) begin
                cnt_we             = 1'b1;
                cvalid_nxt[in_sym] = 1'b1;
                ready_nxt          = 1'b0;
              end
            end
            REQ_BUILD: begin
              sym_i_nxt = '0;
              pend_nxt  = 1'b0;
              sum_nxt   = '0;
              state_nxt = S_SUM;
            end
            REQ_ENCODE: begin
              if (!ready_r) begin
                ov_nxt    = 1'b1;
                ostat_nxt = ST_NO_TABLE;
              end else if (!sym_in_range) begin
                ov_nxt    = 1'b1;
                ostat_nxt = ST_ZERO_SYM;
              end else begin
                state_nxt = S_ENC_SYM;
              end
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end

      // Sum all counts, one read per cycle
      S_SUM: begin
        pend_nxt = 1'b1;
        if (pend_r) sum_nxt = total;
        if (sym_i_r == LAST_SYM) begin
          state_nxt = S_SUMCHK;
        end else begin
          sym_i_nxt = sym_i_r + SYM_W'(1);
        end
      end

      S_SUMCHK: begin
        if (CMP_W'(total) != CMP_W'(l_val)) begin
          ready_nxt = 1'b0;
          ov_nxt    = 1'b1;
          ostat_nxt = ST_BAD_SUM;
          state_nxt = S_IDLE;
        end else begin
          sym_i_nxt = '0;
          cum_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = S_RDCNT;
        end
      end

      S_RDCNT: state_nxt = S_SYMW;

      // Write the symbol entry and start its spread
      S_SYMW: begin
        sym_we   = 1'b1;
        nidx_we  = 1'b1;
        cum_nxt  = cum_r + bf;
        left_nxt = bf;
        if (bf != '0) begin
          state_nxt = S_SPREAD;
        end else if (sym_i_r == LAST_SYM) begin
          tcnt_nxt  = '0;
          state_nxt = S_TR_RD;
        end else begin
          sym_i_nxt = sym_i_r + SYM_W'(1);
          state_nxt = S_RDCNT;
        end
      end

      S_SPREAD: begin
        spr_we   = 1'b1;
        idx_nxt  = TBL_W'((ST_W'(idx_r) + step) & ST_W'(l_mask));
        left_nxt = left_r - ST_W'(1);
        if (left_r == ST_W'(1)) begin
          if (sym_i_r == LAST_SYM) begin
            tcnt_nxt  = '0;
            state_nxt = S_TR_RD;
          end else begin
            sym_i_nxt = sym_i_r + SYM_W'(1);
            state_nxt = S_RDCNT;
          end
        end
      end

      // Transition fill: slot -> symbol -> next index -> write
      S_TR_RD: state_nxt = S_TR_SYM;

      S_TR_SYM: begin
        s_nxt     = spr_rd;
        state_nxt = S_TR_WR;
      end

      S_TR_WR: begin
        tr_we   = 1'b1;
        nidx_we = 1'b1;
        nidx_wa = s_r;
        nidx_wd = nidx_rd + ST_W'(1);
        if (tcnt_r == l_mask) begin
          cur_nxt   = l_val;
          ready_nxt = 1'b1;
          ov_nxt    = 1'b1;
          ost_nxt   = l_val;
          state_nxt = S_IDLE;
        end else begin
          tcnt_nxt  = tcnt_r + TBL_W'(1);
          state_nxt = S_TR_RD;
        end
      end

      S_ENC_SYM: begin
        if (ent.f == '0) begin
          ov_nxt    = 1'b1;
          ostat_nxt = ST_ZERO_SYM;
          state_nxt = S_IDLE;
        end else begin
          enc_bits_nxt = ebits[TBL_W-1:0];
          enc_nb_nxt   = enb;
          state_nxt    = S_ENC_TR;
        end
      end

      S_ENC_TR: begin
        cur_nxt   = tr_rd;
        ov_nxt    = 1'b1;
        obits_nxt = enc_bits_r;
        onb_nxt   = enc_nb_r;
        ost_nxt   = tr_rd;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // Register write invalidates the tables
    if (cfg_valid) begin
      log_nxt   = cfg_table_log;
      ready_nxt = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      log_r    <= LOG_W'(MAX_TABLE_LOG);
      ready_r  <= 1'b0;
      cur_r    <= '0;
      pend_r   <= 1'b0;
      cvalid_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      log_r    <= log_nxt;
      ready_r  <= ready_nxt;
      cur_r    <= cur_nxt;
      pend_r   <= pend_nxt;
      cvalid_r <= cvalid_nxt;
      ov_r     <= ov_nxt;
    end
    sym_i_r    <= sym_i_nxt;
    sum_r      <= sum_nxt;
    cum_r      <= cum_nxt;
    left_r     <= left_nxt;
    idx_r      <= idx_nxt;
    tcnt_r     <= tcnt_nxt;
    s_r        <= s_nxt;
    enc_bits_r <= enc_bits_nxt;
    enc_nb_r   <= enc_nb_nxt;
    cvld_r     <= cvld_nxt;
    obits_r    <= obits_nxt;
    onb_r      <= onb_nxt;
    ost_r      <= ost_nxt;
    ostat_r    <= ostat_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = ov_r;
  assign out_code_bits   = obits_r;
  assign out_bit_count   = onb_r;
  assign out_coder_state = ost_r;
  assign out_status      = ostat_r;

  // Tables become ready only with a good build result
  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> (out_valid && out_status == ST_OK))
    else $error("tables ready without build result");

  // Emitted bits fit in the reported count
  a_bits_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((ST_W'(out_code_bits) >> out_bit_count) == '0))
    else $error("code bits exceed bit count");

  // Failed sum leaves tables unbuilt
  a_bad_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_BAD_SUM) |-> !ready_r)
    else $error("tables ready after bad sum");

  // Register write clears ready
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !ready_r)
    else $error("ready survived config write");

  // Error results carry no bits
  a_err_nobits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_bit_count == '0))
    else $error("error result carries bits");

endmodule

### hw/rtl/tans_ram.sv
module tans_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### verif/tans_encode_checker.sv
`timescale 1ns / 1ps

module tans_encode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_symbol,
  input  logic [12:0] in_count_value,
  input  logic        out_valid,
  input  logic [11:0] out_code_bits,
  input  logic [3:0]  out_bit_count,
  input  logic [12:0] out_coder_state,
  input  logic [1:0]  out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_table_log,
  output int          mismatches,
  output int          pending
);

  import tans_pkg::*;

  typedef struct packed {
    logic [11:0] code;
    logic [3:0]  nbits;
    logic [12:0] coder;
    status_t     stat;
  } coded_item_t;

  coded_item_t expected_q[$];

  // predictor state
  logic [3:0] log_reg;
  int         counts[256];
  int         slot_sym[4096];
  int         cum[256];
  int         shift_amt[256];
  int         thresh[256];
  int         next_state_tbl[4096];
  int         coder;
  bit         ready;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // table build; returns status
  function automatic status_t build_tables();
    int lg, tsize, total, pos, stride, nb, f;
    int nxt[256];
    lg = (log_reg < 4) ? 4 : (log_reg > 12) ? 12 : int'(log_reg);
    tsize = 1 << lg;
    total = 0;
    foreach (counts[i]) total += counts[i];
    if (total != tsize) begin
      ready = 0;
      return ST_BAD_SUM;
    end
    stride = (tsize >> 3) * 5 + 3;
    pos = 0;
    for (int s = 0; s < 256; s++) begin
      for (int j = 0; j < counts[s]; j++) begin
        slot_sym[pos & 4095] = s;
        pos = (pos + stride) & (tsize - 1);
      end
    end
    total = 0;
    for (int s = 0; s < 256; s++) begin
      f = counts[s];
      nb = 1;
      if (f != 0) begin
        nb = 0;
        while (nb < lg && (f << (nb + 1)) <= tsize) nb++;
      end
      shift_amt[s] = nb;
      thresh[s] = (2 * f) << nb;
      cum[s] = total;
      nxt[s] = total;
      total += f;
    end
    for (int x = tsize; x < 2 * tsize; x++) begin
      int s;
      s = slot_sym[(x - tsize) & 4095];
      next_state_tbl[nxt[s] & 4095] = x;
      nxt[s]++;
    end
    coder = tsize;
    ready = 1;
    return ST_OK;
  endfunction

  function automatic coded_item_t predict(input req_t req, input int sym, input int cnt);
    coded_item_t r;
    int nb, pos;
    r = '0;
    r.stat = ST_OK;
    case (req)
      REQ_LOAD: begin
        counts[sym] = cnt;
        ready = 0;
      end
      REQ_BUILD: r.stat = build_tables();
      REQ_ENCODE: begin
        if (!ready) r.stat = ST_NO_TABLE;
        else if (counts[sym] == 0) r.stat = ST_ZERO_SYM;
        else begin
          nb = shift_amt[sym];
          if (coder >= thresh[sym]) nb++;
          r.code = 12'(coder & ((1 << nb) - 1));
          r.nbits = 4'(nb);
          pos = cum[sym] + (coder >> nb) - counts[sym];
          coder = next_state_tbl[pos & 4095];
        end
      end
      default: ;
    endcase
    r.coder = 13'(coder);
    return r;
  endfunction

  always @(posedge clk) begin
    coded_item_t e;
    if (!rst_n) begin
      log_reg <= 4'd12;
      foreach (counts[i]) counts[i] = 0;
      coder = 0;
      ready = 0;
      expected_q.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      // compare results first: no item answers on its own acceptance edge
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_code_bits !== e.code)
            report("code_bits", int'(out_code_bits), int'(e.code));
          if (out_bit_count !== e.nbits)
            report("bit_count", int'(out_bit_count), int'(e.nbits));
          if (out_coder_state !== e.coder)
            report("coder_state", int'(out_coder_state), int'(e.coder));
          if (out_status !== e.stat)
            report("status", int'(out_status), int'(e.stat));
        end
      end
      if (cfg_valid && cfg_ready) begin
        log_reg <= cfg_table_log;
        ready = 0;
      end
      if (start && !busy)
        expected_q.push_back(predict(req_t'(in_req_type), int'(in_symbol),
                                     int'(in_count_value)));
      pending <= expected_q.size();
    end
  end

endmodule

### verif/tb_tans_table_build_and_encode.sv
`timescale 1ns / 1ps

module tb_tans_table_build_and_encode;
  import tans_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [7:0]  in_symbol;
  logic [12:0] in_count_value;
  logic        out_valid;
  logic [11:0] out_code_bits;
  logic [3:0]  out_bit_count;
  logic [12:0] out_coder_state;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_table_log;
  int          mismatches;
  int          pending;
  int          cycles;
  int          idle_pct;
  int          items_sent;
  int          shadow_counts[256];

  tans_table_build_and_encode DUT (.*);
  tans_encode_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("FAIL");
      $finish;
    end
  end

  // one item; start is left high on return
  task automatic send(input req_t req, input int sym, input int cnt);
    bit lowered;
    lowered = 0;
    while ($urandom_range(99) < idle_pct) begin
      if (!lowered) start <= 1'b0;
      lowered = 1;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_symbol <= 8'(sym);
    in_count_value <= 13'(cnt);
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req == REQ_LOAD) shadow_counts[sym] = cnt;
    items_sent++;
  endtask

  // drain every outstanding result, block back to idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_log(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_table_log <= 4'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic clear_counts();
    for (int s = 0; s < 256; s++)
      if (shadow_counts[s] != 0) send(REQ_LOAD, s, 0);
  endtask

  // set of counts summing to L (sum occasionally broken), build, then a run of encodes with some no-ops
  task automatic coding_set(input int cfg_val, input int n_enc);
    int lg, tsize, k, remaining, s, pick;
    int syms[$];
    bit taken[256];
    write_log(cfg_val);
    lg = (cfg_val < 4) ? 4 : (cfg_val > 12) ? 12 : cfg_val;
    tsize = 1 << lg;
    clear_counts();
    k = $urandom_range(1, (tsize < 12) ? tsize : 12);
    while (syms.size() < k) begin
      s = $urandom_range(255);
      if (!taken[s]) begin
        taken[s] = 1'b1;
        syms.push_back(s);
      end
    end
    remaining = tsize;
    foreach (syms[i]) begin
      pick = (i == k - 1) ? remaining : $urandom_range(1, remaining - (k - 1 - i));
      send(REQ_LOAD, syms[i], pick);
      remaining -= pick;
    end
    // occasionally break the sum
    if ($urandom_range(9) == 0) send(REQ_LOAD, syms[0], $urandom_range(8191));
    send(REQ_BUILD, $urandom_range(255), $urandom_range(8191));
    for (int i = 0; i < n_enc; i++) begin
      case ($urandom_range(19))
        0: send(REQ_ENCODE, $urandom_range(255), $urandom_range(8191));
        1: send(REQ_NOP, $urandom_range(255), $urandom_range(8191));
        default: send(REQ_ENCODE, syms[$urandom_range(k - 1)], $urandom_range(8191));
      endcase
    end
    // rare mid-stream load drops the tables
    if ($urandom_range(7) == 0) begin
      send(REQ_LOAD, syms[0], shadow_counts[syms[0]]);
      send(REQ_ENCODE, syms[0], 0);
    end
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    in_req_type = REQ_NOP;
    in_symbol = 0;
    in_count_value = 0;
    cfg_valid = 0;
    cfg_table_log = 0;
    idle_pct = 0;
    cycles = 0;
    items_sent = 0;
    foreach (shadow_counts[i]) shadow_counts[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unbuilt tables, no-op, empty sum, extreme counts
    send(REQ_ENCODE, 0, 0);
    send(REQ_NOP, 255, 8191);
    send(REQ_BUILD, 0, 0);
    send(REQ_LOAD, 170, 8191);
    send(REQ_LOAD, 85, 4096);
    send(REQ_BUILD, 0, 0);
    send(REQ_LOAD, 170, 0);
    send(REQ_BUILD, 255, 0);
    send(REQ_ENCODE, 85, 0);
    send(REQ_ENCODE, 255, 0);
    send(REQ_ENCODE, 85, 0);
    send(REQ_LOAD, 85, 0);
    // saturated low log, single symbol and two symbols
    write_log(0);
    send(REQ_LOAD, 255, 16);
    send(REQ_BUILD, 0, 0);
    send(REQ_ENCODE, 255, 0);
    send(REQ_ENCODE, 0, 0);
    send(REQ_LOAD, 255, 1);
    send(REQ_LOAD, 0, 15);
    send(REQ_BUILD, 0, 0);
    send(REQ_ENCODE, 255, 0);
    send(REQ_ENCODE, 0, 0);
    send(REQ_ENCODE, 255, 0);
    // config write drops the tables
    write_log(4);
    send(REQ_ENCODE, 0, 0);
    coding_set(15, 20);
    coding_set(12, 10);
    coding_set(3, 15);

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 85 : (ph == 3) ? 29 : 0;
      repeat (8) begin
        if ($urandom_range(14) == 0) coding_set($urandom_range(9, 15), $urandom_range(10, 40));
        else coding_set($urandom_range(0, 8), $urandom_range(20, 50));
        // noise: random loads then a build that usually fails
        if ($urandom_range(3) == 0) begin
          repeat (3) send(REQ_LOAD, $urandom_range(255), $urandom_range(8191));
          send(REQ_BUILD, $urandom_range(255), $urandom_range(8191));
          send(REQ_ENCODE, $urandom_range(255), $urandom_range(8191));
        end
        if (items_sent > 1100) break;
      end
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
